/* sv/sla_pkg.sv */
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and character codes for the serial line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int RX_W   = 8;
    localparam int LEN_W  = 6;
    localparam int KIND_W = 2;

    localparam logic [RX_W-1:0] CH_DROP      = 8'h1A;
    localparam logic [RX_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [RX_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [RX_W-1:0] CH_NOBUF     = 8'h21;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO    = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RDREQ,
        ST_CONTENT,
        ST_END,
        ST_ECHO
    } state_t;

endpackage

/* sv/sla_line_mem.sv */
// ----------------------------------------------------------------------------
// sla_line_mem
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sla_line_mem #(
    parameter int DEPTH  = 20,
    parameter int ADDR_W = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic [sla_pkg::RX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic [sla_pkg::RX_W-1:0] rd_data
);
    import sla_pkg::*;

    logic [RX_W-1:0] mem [DEPTH];
    logic [RX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sla_ctrl.sv */
// ----------------------------------------------------------------------------
// sla_ctrl
// Command decode, line state, read-out sequencer and result register.
// ----------------------------------------------------------------------------
module sla_ctrl #(
    parameter int LINE_CAPACITY = 20,
    parameter int ADDR_W        = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [sla_pkg::RX_W-1:0]   s_rx_byte,
    input  logic                       s_pool_empty,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sla_pkg::KIND_W-1:0] m_kind,
    output logic [sla_pkg::RX_W-1:0]   m_data,
    output logic [sla_pkg::LEN_W-1:0]  m_line_length,
    output logic                       m_last,
    output logic                       mem_wr_en,
    output logic [ADDR_W-1:0]          mem_wr_addr,
    output logic [sla_pkg::RX_W-1:0]   mem_wr_data,
    output logic                       mem_rd_en,
    output logic [ADDR_W-1:0]          mem_rd_addr,
    input  logic [sla_pkg::RX_W-1:0]   mem_rd_data
);
    import sla_pkg::*;

    localparam logic [ADDR_W-1:0] FULL_FILL = ADDR_W'(LINE_CAPACITY - 1);

    state_t              state_reg, state_next;
    logic                held_reg, held_next;
    logic [ADDR_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [RX_W-1:0]     rx_reg;
    logic                pool_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [RX_W-1:0]     out_data_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_last_reg;

    logic                accept;
    logic                out_free;
    logic                emit;
    kind_t               emit_kind;
    logic [RX_W-1:0]     emit_data;
    logic [LEN_W-1:0]    emit_len;
    logic                emit_last;
    logic [ADDR_W-1:0]   fill_eff;
    logic                idx_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign fill_eff = held_reg ? fill_reg : '0;
    assign idx_done = ({1'b0, idx_reg} + 1'b1) == {1'b0, fill_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (held_reg || !pool_reg) begin
                        if (rx_reg == CH_NEWLINE) begin
                            if (fill_eff != '0) begin
                                state_next = ST_RDREQ;
                            end
                        end else if (rx_reg != CH_DROP && rx_reg != CH_BACKSPACE &&
                                     fill_eff >= FULL_FILL) begin
                            state_next = ST_ECHO;
                        end
                    end
                end
            end
            ST_RDREQ: state_next = ST_CONTENT;
            ST_CONTENT: begin
                if (out_free && idx_done) begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        emit        = 1'b0;
        emit_kind   = KIND_ECHO;
        emit_data   = '0;
        emit_len    = '0;
        emit_last   = 1'b1;
        held_next   = held_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = fill_eff;
        mem_wr_data = rx_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        unique case (state_reg)
            ST_DECIDE: begin
                if (out_free) begin
                    if (!held_reg && pool_reg) begin
                        emit      = 1'b1;
                        emit_data = CH_NOBUF;
                    end else begin
                        held_next = 1'b1;
                        fill_next = fill_eff;
                        priority if (rx_reg == CH_DROP) begin
                            emit      = 1'b1;
                            emit_kind = KIND_END;
                            held_next = 1'b0;
                            fill_next = '0;
                        end else if (rx_reg == CH_NEWLINE) begin
                            idx_next = '0;
                            if (fill_eff == '0) begin
                                emit      = 1'b1;
                                emit_kind = KIND_END;
                                held_next = 1'b0;
                            end
                        end else if (rx_reg == CH_BACKSPACE) begin
                            if (fill_eff != '0) begin
                                emit      = 1'b1;
                                emit_data = rx_reg;
                                fill_next = fill_eff - 1'b1;
                            end
                        end else if (fill_eff >= FULL_FILL) begin
                            // full line: drop it, echo the byte next
                            emit      = 1'b1;
                            emit_kind = KIND_END;
                            emit_last = 1'b0;
                            held_next = 1'b0;
                            fill_next = '0;
                        end else begin
                            mem_wr_en = 1'b1;
                            fill_next = fill_eff + 1'b1;
                            emit      = 1'b1;
                            emit_data = rx_reg;
                        end
                    end
                end
            end
            ST_RDREQ: begin
                mem_rd_en = 1'b1;
            end
            ST_CONTENT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_CONTENT;
                    emit_data = mem_rd_data;
                    emit_last = 1'b0;
                    if (!idx_done) begin
                        idx_next    = idx_reg + 1'b1;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_reg + 1'b1;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                    emit_len  = LEN_W'(fill_reg);
                    held_next = 1'b0;
                    fill_next = '0;
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_data = rx_reg;
                end
            end
            ST_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            held_reg      <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            held_reg  <= held_next;
            fill_reg  <= fill_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (accept) begin
            rx_reg   <= s_rx_byte;
            pool_reg <= s_pool_empty;
        end
        if (emit) begin
            out_kind_reg <= emit_kind;
            out_data_reg <= emit_data;
            out_len_reg  <= emit_len;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_data        = out_data_reg;
    assign m_line_length = out_len_reg;
    assign m_last        = out_last_reg;

    a_fill_needs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != '0) |-> held_reg)
        else $error("fill count set without a held line");

    a_read_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONTENT) |-> (idx_reg < fill_reg))
        else $error("line read beyond stored bytes");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_last) |=> (state_reg == ST_IDLE))
        else $error("final result issued while item still in work");

    a_write_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (mem_wr_addr < FULL_FILL && state_reg == ST_DECIDE))
        else $error("line store write outside the open line");

endmodule

/* sv/serial_line_assembler_with_echo_top.sv */
// ----------------------------------------------------------------------------
// serial_line_assembler_with_echo_top
// Assembles received serial bytes into command lines with echo.
// ----------------------------------------------------------------------------
// Input channel s_*: one received byte per transaction, s_tuser flags that no
// free line buffer is available. Result channel m_*: echo bytes, line content
// bytes and end markers; m_tlast marks the final result of one input byte.
// A byte that gives no result (backspace on an empty line) simply completes.
// Sequence: an input is taken in ST_IDLE and decided in ST_DECIDE once the result
// register is free. A newline over a line of N bytes issues a read request in
// ST_RDREQ, then gives N content bytes read one per cycle from the registered line
// store while the receiver takes them, then the end marker. A byte at a full line
// drops the line: an end marker, then the echo of the byte. The line-store read port sets the read-out pace.
// The result register decouples the sides: a new byte is taken while the
// previous result still waits. When the receiver stalls, work holds until the
// result register frees; nothing is lost.
// Reset clears the held-line flag and fill count; the line store needs no
// clearing since only bytes written in the open line are read back.
// ----------------------------------------------------------------------------
module serial_line_assembler_with_echo_top #(
    parameter int LINE_CAPACITY = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] pool_empty
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data, [13:8] line_length, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import sla_pkg::*;

    localparam int ADDR_W = $clog2(LINE_CAPACITY);

    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [RX_W-1:0]    mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [RX_W-1:0]    mem_rd_data;
    logic [RX_W-1:0]    out_data;
    logic [LEN_W-1:0]   out_len;

    sla_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_rx_byte     (s_tdata),
        .s_pool_empty  (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_kind        (m_tuser),
        .m_data        (out_data),
        .m_line_length (out_len),
        .m_last        (m_tlast),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    sla_line_mem #(
        .DEPTH  (LINE_CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_tdata = {2'b00, out_len, out_data};

endmodule
